// File: hw/rtl/plic_pkg.sv
// ----------------------------------------------------------------------------
// plic_pkg
// Shared types and constants of the platform interrupt controller core.
// ----------------------------------------------------------------------------
package plic_pkg;

   // Fixed field widths
   localparam int SOURCE_SLOTS   = 32;
   localparam int ID_WIDTH       = 5;
   localparam int PRIO_WIDTH     = 3;
   localparam int NIBBLE_WIDTH   = 4;
   localparam int COMMAND_WIDTH  = 2;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 64;

   // Highest priority; nibbles above it saturate
   localparam logic [PRIO_WIDTH-1:0] MAX_PRIORITY = 3'd7;

   // Transaction command codes
   localparam logic [COMMAND_WIDTH-1:0] CMD_SAMPLE   = 2'd0;
   localparam logic [COMMAND_WIDTH-1:0] CMD_CLAIM    = 2'd1;
   localparam logic [COMMAND_WIDTH-1:0] CMD_COMPLETE = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRIO_LOW  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRIO_HIGH = 2'd3;

   // Per-transaction control broadcast to every lane
   typedef struct packed {
      logic                     accept;
      logic [COMMAND_WIDTH-1:0] command;
      logic                     grant_valid;
      logic [ID_WIDTH-1:0]      grant_id;
      logic [ID_WIDTH-1:0]      complete_id;
   } lane_step_type;

   // What one lane reports to the merge stage and the top level
   typedef struct packed {
      logic                  qualify;
      logic [PRIO_WIDTH-1:0] prio;
      logic                  pending;
      logic                  claimed;
      logic                  pending_next;
      logic                  request_next;
   } lane_status_type;

   // Node of the priority merge tree
   typedef struct packed {
      logic                  hit;
      logic [PRIO_WIDTH-1:0] prio;
      logic [ID_WIDTH-1:0]   id;
   } merge_node_type;

endpackage

// File: hw/rtl/plic_if.sv
// ----------------------------------------------------------------------------
// plic_if
// Valid/ready channels of the interrupt controller core: request and response.
// ----------------------------------------------------------------------------
interface plic_req_if;
   logic                                valid;
   logic                                ready;
   logic [plic_pkg::COMMAND_WIDTH-1:0]  command;
   logic [plic_pkg::SOURCE_SLOTS-1:0]   source_levels;
   logic [plic_pkg::ID_WIDTH-1:0]       complete_id;

   modport source (output valid, command, source_levels, complete_id, input ready);
   modport sink   (input valid, command, source_levels, complete_id, output ready);
endinterface

interface plic_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [plic_pkg::ID_WIDTH-1:0]       claim_id;
   logic                                interrupt_request;
   logic [plic_pkg::SOURCE_SLOTS-1:0]   pending_sources;

   modport source (output valid, claim_id, interrupt_request, pending_sources,
                   input ready);
   modport sink   (input valid, claim_id, interrupt_request, pending_sources,
                   output ready);
endinterface

// File: hw/rtl/plic_lane.sv
// ----------------------------------------------------------------------------
// plic_lane
// One interrupt source: gateway, pending and claimed bits, priority decode.
// ----------------------------------------------------------------------------
module plic_lane #(
   parameter int LANE_ID = 1
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  plic_pkg::lane_step_type               step,
   input  logic                                  level,
   input  logic                                  enable,
   input  logic [plic_pkg::PRIO_WIDTH-1:0]       threshold,
   input  logic [plic_pkg::NIBBLE_WIDTH-1:0]     nibble,
   output plic_pkg::lane_status_type             status
);

   logic                              pending_ff, pending_in;
   logic                              claimed_ff, claimed_in;
   logic [plic_pkg::PRIO_WIDTH-1:0]   prio;
   logic                              above;
   logic                              granted;
   logic                              completed;

   // Saturate the nibble to the top priority
   assign prio  = nibble[plic_pkg::NIBBLE_WIDTH-1] ? plic_pkg::MAX_PRIORITY
                                                   : nibble[plic_pkg::PRIO_WIDTH-1:0];
   assign above = (prio > threshold);

   assign granted   = step.grant_valid
                      && (step.grant_id == plic_pkg::ID_WIDTH'(LANE_ID));
   assign completed = (step.complete_id == plic_pkg::ID_WIDTH'(LANE_ID));

   // Gateway update for this transaction
   always_comb begin
      pending_in = pending_ff;
      claimed_in = claimed_ff;
      if (step.accept) begin
         unique case (step.command)
            plic_pkg::CMD_SAMPLE: begin
               pending_in = pending_ff | (level & ~claimed_ff);
            end
            plic_pkg::CMD_CLAIM: begin
               if (granted) begin
                  pending_in = 1'b0;
                  claimed_in = 1'b1;
               end
            end
            plic_pkg::CMD_COMPLETE: begin
               if (completed) begin
                  claimed_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         claimed_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         claimed_ff <= claimed_in;
      end
   end

   // Report to merge stage
   assign status.qualify      = pending_ff & enable & above;
   assign status.prio         = prio;
   assign status.pending      = pending_ff;
   assign status.claimed      = claimed_ff;
   assign status.pending_next = pending_in;
   assign status.request_next = pending_in & enable & above;

endmodule

// File: hw/rtl/plic_merge.sv
// ----------------------------------------------------------------------------
// plic_merge
// Priority tree over all lanes: highest priority wins, lowest ID on a tie.
// ----------------------------------------------------------------------------
module plic_merge (
   input  plic_pkg::lane_status_type [plic_pkg::SOURCE_SLOTS-1:0] lanes,
   output logic                                                  winner_valid,
   output logic [plic_pkg::ID_WIDTH-1:0]                         winner_id
);

   localparam int LEVELS = plic_pkg::ID_WIDTH;

   plic_pkg::merge_node_type tree [0:LEVELS][0:plic_pkg::SOURCE_SLOTS-1];

   // Right node takes over only with strictly higher priority
   function automatic plic_pkg::merge_node_type pick(
      input plic_pkg::merge_node_type lo,
      input plic_pkg::merge_node_type hi
   );
      plic_pkg::merge_node_type res;
      res = lo;
      if (hi.hit && (!lo.hit || (hi.prio > lo.prio))) begin
         res = hi;
      end
      return res;
   endfunction

   // Leaves
   for (genvar i = 0; i < plic_pkg::SOURCE_SLOTS; i++) begin : g_leaf
      assign tree[0][i].hit  = lanes[i].qualify;
      assign tree[0][i].prio = lanes[i].prio;
      assign tree[0][i].id   = plic_pkg::ID_WIDTH'(i);
   end

   // Pairwise reduction, lower IDs on the left
   for (genvar l = 1; l <= LEVELS; l++) begin : g_level
      for (genvar j = 0; j < plic_pkg::SOURCE_SLOTS; j++) begin : g_node
         if (j < (plic_pkg::SOURCE_SLOTS >> l)) begin : g_used
            assign tree[l][j] = pick(tree[l-1][2*j], tree[l-1][2*j+1]);
         end else begin : g_unused
            assign tree[l][j] = '0;
         end
      end
   end

   assign winner_valid = tree[LEVELS][0].hit;
   assign winner_id    = tree[LEVELS][0].hit ? tree[LEVELS][0].id : '0;

endmodule

// File: hw/rtl/plic_interrupt_controller_core.sv
// ----------------------------------------------------------------------------
// plic_interrupt_controller_core
// Single-context platform interrupt controller for up to 31 level sources.
// ----------------------------------------------------------------------------
// The core takes one transaction per clock (sample, claim or complete) while
// the receiver keeps taking responses, and returns one response per
// transaction in the next cycle through an output register; a new request
// is taken in the same cycle the previous response is taken. Each source
// has its own lane holding its gateway and pending/claimed bits, and a
// combinational priority tree across the lanes picks the claim winner.
// Configuration writes take effect on the next transaction.
// ----------------------------------------------------------------------------
module plic_interrupt_controller_core #(
   parameter int NUM_SOURCES = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   plic_req_if.sink                               req_if,
   plic_rsp_if.source                             rsp_if,
   input  logic                                   csr_write_enable,
   input  logic [plic_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [plic_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   localparam int HALF = plic_pkg::SOURCE_SLOTS / 2;

   // Configuration registers
   logic [plic_pkg::SOURCE_SLOTS-1:0]    enable_ff;
   logic [plic_pkg::PRIO_WIDTH-1:0]      threshold_ff;
   logic [plic_pkg::CSR_DATA_WIDTH-1:0]  prio_low_ff;
   logic [plic_pkg::CSR_DATA_WIDTH-1:0]  prio_high_ff;

   // Response register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [plic_pkg::ID_WIDTH-1:0]        claim_id_ff, claim_id_in;
   logic                                 irq_ff, irq_in;
   logic [plic_pkg::SOURCE_SLOTS-1:0]    pending_ff, pending_in;

   logic                                 req_accept;
   plic_pkg::lane_step_type              step;
   plic_pkg::lane_status_type [plic_pkg::SOURCE_SLOTS-1:0] lanes;
   logic                                 winner_valid;
   logic [plic_pkg::ID_WIDTH-1:0]        winner_id;
   logic [plic_pkg::SOURCE_SLOTS-1:0]    pending_now;
   logic [plic_pkg::SOURCE_SLOTS-1:0]    claimed_now;
   logic [plic_pkg::SOURCE_SLOTS-1:0]    pending_next;
   logic [plic_pkg::SOURCE_SLOTS-1:0]    request_next;
   logic                                 is_claim;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         threshold_ff <= '0;
         prio_low_ff  <= '0;
         prio_high_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            plic_pkg::CSR_ENABLE:    enable_ff    <= csr_write_data[plic_pkg::SOURCE_SLOTS-1:0];
            plic_pkg::CSR_THRESHOLD: threshold_ff <= csr_write_data[plic_pkg::PRIO_WIDTH-1:0];
            plic_pkg::CSR_PRIO_LOW:  prio_low_ff  <= csr_write_data;
            plic_pkg::CSR_PRIO_HIGH: prio_high_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Handshake: output register frees up when taken
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   assign is_claim = (req_if.command == plic_pkg::CMD_CLAIM);

   // Broadcast to lanes
   assign step.accept      = req_accept;
   assign step.command     = req_if.command;
   assign step.grant_valid = winner_valid && is_claim;
   assign step.grant_id    = winner_id;
   assign step.complete_id = req_if.complete_id;

   // Source lanes; ID 0 and IDs past the source count stay empty
   for (genvar i = 0; i < plic_pkg::SOURCE_SLOTS; i++) begin : g_lane
      if ((i >= 1) && (i < NUM_SOURCES)) begin : g_src
         plic_lane #(
            .LANE_ID (i)
         ) u_lane (
            .clock     (clock),
            .reset     (reset),
            .step      (step),
            .level     (req_if.source_levels[i]),
            .enable    (enable_ff[i]),
            .threshold (threshold_ff),
            .nibble    ((i < HALF) ? prio_low_ff[plic_pkg::NIBBLE_WIDTH*(i % HALF) +:
                                                 plic_pkg::NIBBLE_WIDTH]
                                   : prio_high_ff[plic_pkg::NIBBLE_WIDTH*(i % HALF) +:
                                                  plic_pkg::NIBBLE_WIDTH]),
            .status    (lanes[i])
         );
      end else begin : g_none
         assign lanes[i] = '0;
      end
      assign pending_now[i]  = lanes[i].pending;
      assign claimed_now[i]  = lanes[i].claimed;
      assign pending_next[i] = lanes[i].pending_next;
      assign request_next[i] = lanes[i].request_next;
   end

   // Winner across lanes
   plic_merge u_merge (
      .lanes        (lanes),
      .winner_valid (winner_valid),
      .winner_id    (winner_id)
   );

   // Response capture
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      claim_id_in  = claim_id_ff;
      irq_in       = irq_ff;
      pending_in   = pending_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         claim_id_in  = (is_claim && winner_valid) ? winner_id : '0;
         irq_in       = |request_next;
         pending_in   = pending_next;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      claim_id_ff <= claim_id_in;
      irq_ff      <= irq_in;
      pending_ff  <= pending_in;
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.claim_id          = claim_id_ff;
   assign rsp_if.interrupt_request = irq_ff;
   assign rsp_if.pending_sources   = pending_ff;

`ifndef NO_ASSERTIONS
   // A source is never pending and claimed at once
   a_pend_claim_excl: assert property (@(posedge clock) disable iff (reset)
      (pending_now & claimed_now) == '0)
      else $error("source both pending and claimed");

   // Reserved source 0 never becomes pending or claimed
   a_src0_idle: assert property (@(posedge clock) disable iff (reset)
      !pending_now[0] && !claimed_now[0])
      else $error("reserved source active");

   // A claimed ID in the response has left the pending set
   a_claim_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (claim_id_ff != '0)) |-> !pending_ff[claim_id_ff])
      else $error("claimed source still pending");

   // A granted source is claimed in the next cycle
   a_grant_claims: assert property (@(posedge clock) disable iff (reset)
      (req_accept && step.grant_valid) |=> claimed_now[$past(winner_id)])
      else $error("grant did not mark source claimed");

   // Response register is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");
`endif

endmodule

// File: sim/tb_plic_interrupt_controller_core.sv
// ----------------------------------------------------------------------------
// tb_plic_interrupt_controller_core
// Self-checking testbench of the single-context interrupt controller core.
// ----------------------------------------------------------------------------
// Drives sample, claim and complete transactions into the request channel
// and checks every response against a cycle-free software copy of the
// controller that tracks pending and claimed bits and the register values.
// Directed tests cover reset behavior, priority saturation and tie breaking,
// ignored completes, the unused command and a long receiver stall. Random
// phases then reprogram the registers (extremes included) and run mixed
// traffic with random gaps on both channels and a stretch without gaps.
// ----------------------------------------------------------------------------
module tb_plic_interrupt_controller_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [plic_pkg::COMMAND_WIDTH-1:0] CMD_UNUSED = 2'd3;
   localparam logic [plic_pkg::SOURCE_SLOTS-1:0]  VALID_MASK = 32'hFFFF_FFFE;

   // One response as the controller should report it
   typedef struct packed {
      logic [plic_pkg::ID_WIDTH-1:0]     claim_id;
      logic                              interrupt_request;
      logic [plic_pkg::SOURCE_SLOTS-1:0] pending_sources;
   } plic_outcome_type;

   logic clock;
   logic reset;
   logic                                 csr_write_enable;
   logic [plic_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [plic_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;

   plic_req_if req_ch ();
   plic_rsp_if rsp_ch ();

   plic_interrupt_controller_core #(
      .NUM_SOURCES (32)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the controller
   logic [plic_pkg::SOURCE_SLOTS-1:0] mdl_pending;
   logic [plic_pkg::SOURCE_SLOTS-1:0] mdl_claimed;
   logic [plic_pkg::SOURCE_SLOTS-1:0] cfg_enable;
   logic [plic_pkg::PRIO_WIDTH-1:0]   cfg_threshold;
   logic [63:0]                       cfg_prio_low;
   logic [63:0]                       cfg_prio_high;

   plic_outcome_type outcome_q[$];
   int  mismatch_count = 0;
   bit  gaps_enabled = 1'b1;
   // Hold-off requests from the main sequence; the ready process counts them down
   int  hold_request_len = 0;
   bit  hold_request_tog = 1'b0;
   bit  hold_seen_tog = 1'b0;
   int  rsp_hold_cycles = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("** plic_interrupt_controller_core: FAILED **");
      $finish;
   end

   // Priority of one source, nibble saturated to the top level
   function automatic logic [plic_pkg::PRIO_WIDTH-1:0] source_prio(int id);
      logic [plic_pkg::NIBBLE_WIDTH-1:0] nib;
      if (id < 16) begin
         nib = cfg_prio_low[4*id +: 4];
      end else begin
         nib = cfg_prio_high[4*(id-16) +: 4];
      end
      return nib[3] ? plic_pkg::MAX_PRIORITY : nib[plic_pkg::PRIO_WIDTH-1:0];
   endfunction

   // Highest priority enabled pending source above threshold, lowest ID on tie
   function automatic logic [plic_pkg::ID_WIDTH-1:0] best_candidate();
      logic [plic_pkg::ID_WIDTH-1:0]     best;
      logic [plic_pkg::PRIO_WIDTH-1:0]   best_p;
      logic [plic_pkg::PRIO_WIDTH-1:0]   p;
      logic [plic_pkg::SOURCE_SLOTS-1:0] cand;
      best = '0;
      best_p = '0;
      cand = mdl_pending & cfg_enable & VALID_MASK;
      for (int i = 1; i < plic_pkg::SOURCE_SLOTS; i++) begin
         if (cand[i]) begin
            p = source_prio(i);
            if (p > cfg_threshold && (best == 0 || p > best_p)) begin
               best = plic_pkg::ID_WIDTH'(i);
               best_p = p;
            end
         end
      end
      return best;
   endfunction

   // Apply one transaction to the shadow state and return its response
   function automatic plic_outcome_type step_controller(
      logic [plic_pkg::COMMAND_WIDTH-1:0] cmd,
      logic [plic_pkg::SOURCE_SLOTS-1:0]  levels,
      logic [plic_pkg::ID_WIDTH-1:0]      cid
   );
      plic_outcome_type res;
      logic [plic_pkg::ID_WIDTH-1:0] grant;
      grant = '0;
      case (cmd)
         plic_pkg::CMD_SAMPLE: begin
            mdl_pending = mdl_pending
                          | (levels & VALID_MASK & ~mdl_pending & ~mdl_claimed);
         end
         plic_pkg::CMD_CLAIM: begin
            grant = best_candidate();
            if (grant != 0) begin
               mdl_pending[grant] = 1'b0;
               mdl_claimed[grant] = 1'b1;
            end
         end
         plic_pkg::CMD_COMPLETE: begin
            if (cid != 0 && VALID_MASK[cid] && mdl_claimed[cid]) begin
               mdl_claimed[cid] = 1'b0;
            end
         end
         default: ;
      endcase
      res.claim_id = grant;
      res.interrupt_request = (best_candidate() != 0);
      res.pending_sources = mdl_pending;
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      mismatch_count++;
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, field, want, got);
   endtask

   // Checker and predictor: one process so pop and push never race
   always @(posedge clock) begin
      plic_outcome_type want;
      if (reset) begin
         mdl_pending = '0;
         mdl_claimed = '0;
         cfg_enable = '0;
         cfg_threshold = '0;
         cfg_prio_low = '0;
         cfg_prio_high = '0;
         outcome_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch("unexpected response", 64'd0, 64'd1);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_ch.claim_id !== want.claim_id)
                  report_mismatch("claim_id", want.claim_id, rsp_ch.claim_id);
               if (rsp_ch.interrupt_request !== want.interrupt_request)
                  report_mismatch("interrupt_request", want.interrupt_request,
                                  rsp_ch.interrupt_request);
               if (rsp_ch.pending_sources !== want.pending_sources)
                  report_mismatch("pending_sources", want.pending_sources,
                                  rsp_ch.pending_sources);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            outcome_q.push_back(step_controller(req_ch.command, req_ch.source_levels,
                                                req_ch.complete_id));
         end
         if (csr_write_enable) begin
            case (csr_index)
               plic_pkg::CSR_ENABLE:    cfg_enable = csr_write_data[plic_pkg::SOURCE_SLOTS-1:0];
               plic_pkg::CSR_THRESHOLD: cfg_threshold = csr_write_data[plic_pkg::PRIO_WIDTH-1:0];
               plic_pkg::CSR_PRIO_LOW:  cfg_prio_low = csr_write_data;
               plic_pkg::CSR_PRIO_HIGH: cfg_prio_high = csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // Response side: random stalls, or a counted hold-off when requested
   always @(negedge clock) begin
      if (hold_request_tog != hold_seen_tog) begin
         hold_seen_tog = hold_request_tog;
         rsp_hold_cycles = hold_request_len;
      end
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(gaps_enabled && $urandom_range(99) < 9);
      end
   end

   // Send one transaction; optionally complete a source that is claimed now
   task automatic send_item(logic [plic_pkg::COMMAND_WIDTH-1:0] cmd,
                            logic [plic_pkg::SOURCE_SLOTS-1:0] levels,
                            logic [plic_pkg::ID_WIDTH-1:0] cid, bit pick_claimed);
      logic [plic_pkg::ID_WIDTH-1:0] id;
      @(negedge clock);
      while (gaps_enabled && $urandom_range(99) < 9) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      id = cid;
      if (pick_claimed && (mdl_claimed & VALID_MASK) != 0) begin
         do id = plic_pkg::ID_WIDTH'($urandom_range(31, 1)); while (!mdl_claimed[id]);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.source_levels <= levels;
      req_ch.complete_id <= id;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid and wait until every expected response has been taken
   task automatic idle_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [plic_pkg::CSR_INDEX_WIDTH-1:0] index,
                            logic [plic_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Program all registers; upper bits of the narrow ones get random junk
   task automatic configure(logic [31:0] en, logic [plic_pkg::PRIO_WIDTH-1:0] thr,
                            logic [63:0] lo, logic [63:0] hi);
      write_csr(plic_pkg::CSR_ENABLE, {$urandom(), en});
      write_csr(plic_pkg::CSR_THRESHOLD, {$urandom(), $urandom() & 32'hFFFF_FFF8 | 32'(thr)});
      write_csr(plic_pkg::CSR_PRIO_LOW, lo);
      write_csr(plic_pkg::CSR_PRIO_HIGH, hi);
   endtask

   function automatic logic [plic_pkg::SOURCE_SLOTS-1:0] random_levels();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'd1 << $urandom_range(31);
         2: return $urandom() & $urandom();
         default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
   endfunction

   // Defaults after reset: nothing qualifies since every priority is zero
   task automatic test_reset_state();
      send_item(plic_pkg::CMD_CLAIM, 32'h0, 5'd0, 1'b0);
      send_item(plic_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 5'd0, 1'b0);
      send_item(plic_pkg::CMD_CLAIM, 32'h0, 5'd0, 1'b0);
      send_item(plic_pkg::CMD_COMPLETE, 32'h0, 5'd0, 1'b0);
      send_item(plic_pkg::CMD_COMPLETE, 32'h0, 5'd31, 1'b0);
      send_item(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31, 1'b0);
      idle_until_drained();
   endtask

   // Saturated nibbles, lowest-ID tie break, ignored completes, threshold
   task automatic test_priority_order();
      configure(32'hFFFF_FFFF, 3'd0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
      repeat (4) send_item(plic_pkg::CMD_CLAIM, 32'h0, 5'd0, 1'b0);
      send_item(plic_pkg::CMD_COMPLETE, 32'h0, 5'd1, 1'b0);
      send_item(plic_pkg::CMD_COMPLETE, 32'h0, 5'd1, 1'b0);
      send_item(plic_pkg::CMD_COMPLETE, 32'h0, 5'd0, 1'b0);
      send_item(plic_pkg::CMD_COMPLETE, 32'h0, 5'd30, 1'b0);
      send_item(plic_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 5'd0, 1'b0);
      send_item(plic_pkg::CMD_CLAIM, 32'h0, 5'd0, 1'b0);
      idle_until_drained();
      configure(32'hFFFF_FFFF, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(plic_pkg::CMD_CLAIM, 32'h0, 5'd0, 1'b0);
      idle_until_drained();
      configure(32'h0000_0001, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(plic_pkg::CMD_CLAIM, 32'h0, 5'd0, 1'b0);
      idle_until_drained();
   endtask

   // Long receiver stall while transactions keep coming, then a full drain
   task automatic test_backpressure();
      configure(32'hFFFF_FFFE, 3'd2, {$urandom(), $urandom()}, {$urandom(), $urandom()});
      gaps_enabled = 1'b0;
      hold_request_len = 80;
      hold_request_tog = ~hold_request_tog;
      for (int i = 0; i < 30; i++) begin
         send_item(i % 3 == 0 ? plic_pkg::CMD_SAMPLE :
                   i % 3 == 1 ? plic_pkg::CMD_CLAIM : plic_pkg::CMD_COMPLETE,
                   random_levels(), 5'd0, 1'b1);
      end
      idle_until_drained();
      gaps_enabled = 1'b1;
   endtask

   // Mixed traffic under one register setting
   task automatic run_random_phase(int phase, int count);
      int sel;
      case (phase)
         0: configure(32'hFFFF_FFFF, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
         1: configure(32'h0, 3'd0, {$urandom(), $urandom()}, {$urandom(), $urandom()});
         2: configure(32'hFFFF_FFFF, 3'd7, {$urandom(), $urandom()}, {$urandom(), $urandom()});
         3: configure(32'hFFFF_FFFF, 3'd0, 64'h0, 64'h0);
         default: configure($urandom() | $urandom(), 3'($urandom_range(4)),
                            {$urandom(), $urandom()}, {$urandom(), $urandom()});
      endcase
      gaps_enabled = (phase != 5);
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 38)
            send_item(plic_pkg::CMD_SAMPLE, random_levels(), 5'($urandom()), 1'b0);
         else if (sel < 66)
            send_item(plic_pkg::CMD_CLAIM, $urandom(), 5'($urandom()), 1'b0);
         else if (sel < 88)
            send_item(plic_pkg::CMD_COMPLETE, $urandom(), 5'($urandom()), 1'b1);
         else if (sel < 97)
            send_item(plic_pkg::CMD_COMPLETE, $urandom(), 5'($urandom()), 1'b0);
         else
            send_item(CMD_UNUSED, $urandom(), 5'($urandom()), 1'b0);
      end
      idle_until_drained();
      gaps_enabled = 1'b1;
   endtask

   // Main sequence
   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_ch.valid = 1'b0;
      req_ch.command = plic_pkg::CMD_SAMPLE;
      req_ch.source_levels = '0;
      req_ch.complete_id = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_priority_order();
      test_backpressure();
      for (int p = 0; p < 12; p++) run_random_phase(p, 92);

      idle_until_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** plic_interrupt_controller_core: PASSED **");
      end else begin
         $display("** plic_interrupt_controller_core: FAILED **");
      end
      $finish;
   end

endmodule
